### design/ssstk_pkg.sv
`timescale 1ns / 1ps

package ssstk_pkg;

   localparam int REQ_TYPE_BITS = 3;
   localparam int REQ_NAME_BITS = 16;
   localparam int KIND_BITS     = 4;
   localparam int VALUE_BITS    = 32;
   localparam int SLOT_BITS     = 10;
   localparam int FOUND_BITS    = 9;
   localparam int DEPTH_BITS    = 10;

   localparam int REQ_DATA_BITS = 96;
   localparam int RSP_DATA_BITS = 104;

   localparam logic [REQ_TYPE_BITS-1:0] REQ_PUSH     = 3'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_LOOKUP   = 3'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_READ     = 3'd2;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_RENAME   = 3'd3;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_TRUNCATE = 3'd4;

   localparam logic [KIND_BITS-1:0] KIND_CONST = 4'd5;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

endpackage

### design/ssstk_cell.sv
`timescale 1ns / 1ps

module ssstk_cell
   import ssstk_pkg::*;
#(
   parameter int NAME_BITS = 16
) (
   input  logic                    clock,
   input  logic                    shift_en,
   input  logic [NAME_BITS-1:0]    d_name,
   input  logic [KIND_BITS-1:0]    d_kind,
   input  logic [VALUE_BITS-1:0]   d_first,
   input  logic [VALUE_BITS-1:0]   d_second,
   output logic [NAME_BITS-1:0]    q_name,
   output logic [KIND_BITS-1:0]    q_kind,
   output logic [VALUE_BITS-1:0]   q_first,
   output logic [VALUE_BITS-1:0]   q_second
);

   logic [NAME_BITS-1:0]  name_ff;
   logic [KIND_BITS-1:0]  kind_ff;
   logic [VALUE_BITS-1:0] first_ff;
   logic [VALUE_BITS-1:0] second_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         name_ff   <= d_name;
         kind_ff   <= d_kind;
         first_ff  <= d_first;
         second_ff <= d_second;
      end
   end

   assign q_name   = name_ff;
   assign q_kind   = kind_ff;
   assign q_first  = first_ff;
   assign q_second = second_ff;

endmodule

### design/scoped_symbol_stack.sv
`timescale 1ns / 1ps

// Scoped symbol stack. The entries live in a ring of STACK_DEPTH cells that
// rotates by one cell per clock while a request is being served; only the
// cell at the head of the ring is examined or written. Push, lookup, read and
// rename each rotate the ring once all the way round before the response is
// registered, and no new request is taken until the round is finished.
// Truncate, requests that fail on a full stack or an index past the count,
// and unused codes answer without a scan. A response that waits on
// rsp_tready holds off the next request. A lookup returns the newest
// matching entry. No clearing pass is needed after reset; entries above the
// count are never read.

module scoped_symbol_stack
   import ssstk_pkg::*;
#(
   parameter int STACK_DEPTH = 512,
   parameter int NAME_BITS   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // name_id[15:0], entry_kind[19:16], first_value[51:20],
   // second_value[83:52], slot[93:84], zero pad[95:94]
   input  logic [REQ_DATA_BITS-1:0]   req_tdata,
   // req_type[2:0]
   input  logic [REQ_TYPE_BITS-1:0]   req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // found_slot[8:0], out_name[24:9], out_kind[28:25], out_first[60:29],
   // out_second[92:61], is_constant[93], depth_now[103:94]
   output logic [RSP_DATA_BITS-1:0]   rsp_tdata,
   // status[1:0]
   output logic [1:0]                 rsp_tuser
);

   localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(STACK_DEPTH - 1);

   logic [NAME_BITS-1:0]  cell_name   [STACK_DEPTH];
   logic [KIND_BITS-1:0]  cell_kind   [STACK_DEPTH];
   logic [VALUE_BITS-1:0] cell_first  [STACK_DEPTH];
   logic [VALUE_BITS-1:0] cell_second [STACK_DEPTH];

   state_type state_ff, state_in;
   logic [IW-1:0] rot_ff, rot_in;
   logic [IW-1:0] step_ff, step_in;
   logic [CW-1:0] count_ff, count_in;
   logic [REQ_TYPE_BITS-1:0] op_ff, op_in;
   logic [NAME_BITS-1:0] name_ff, name_in;
   logic [KIND_BITS-1:0] kind_ff, kind_in;
   logic [VALUE_BITS-1:0] first_ff, first_in;
   logic [VALUE_BITS-1:0] second_ff, second_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic found_ff, found_in;
   logic [IW-1:0] best_ff, best_in;

   logic rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   logic [FOUND_BITS-1:0] fslot_ff, fslot_in;
   logic [REQ_NAME_BITS-1:0] oname_ff, oname_in;
   logic [KIND_BITS-1:0] okind_ff, okind_in;
   logic [VALUE_BITS-1:0] ofirst_ff, ofirst_in;
   logic [VALUE_BITS-1:0] osecond_ff, osecond_in;
   logic oconst_ff, oconst_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;

   logic req_fire;
   logic rsp_free;
   logic scanning;
   logic [REQ_TYPE_BITS-1:0]  in_type;
   logic [REQ_NAME_BITS-1:0]  in_name;
   logic [KIND_BITS-1:0]      in_kind;
   logic [VALUE_BITS-1:0]     in_first;
   logic [VALUE_BITS-1:0]     in_second;
   logic [SLOT_BITS-1:0]      in_slot;
   logic [31:0] in_name_w;
   logic [31:0] cnt_w;
   logic [31:0] in_slot_w;
   logic [31:0] idx_w;
   logic [31:0] hold_slot_w;
   logic [31:0] pname_w;
   logic [31:0] cnt_next_w;
   logic hit;
   logic last_step;
   logic wr_all;
   logic wr_name;
   logic [NAME_BITS-1:0]  p_name;
   logic [KIND_BITS-1:0]  p_kind;
   logic [VALUE_BITS-1:0] p_first;
   logic [VALUE_BITS-1:0] p_second;

   // ring of cells, head at cell 0, rotating towards higher cells
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [NAME_BITS-1:0]  d_name;
      logic [KIND_BITS-1:0]  d_kind;
      logic [VALUE_BITS-1:0] d_first;
      logic [VALUE_BITS-1:0] d_second;

      if (i == 0) begin : g_head
         assign d_name   = cell_name[STACK_DEPTH-1];
         assign d_kind   = cell_kind[STACK_DEPTH-1];
         assign d_first  = cell_first[STACK_DEPTH-1];
         assign d_second = cell_second[STACK_DEPTH-1];
      end else if (i == 1) begin : g_patch
         assign d_name   = p_name;
         assign d_kind   = p_kind;
         assign d_first  = p_first;
         assign d_second = p_second;
      end else begin : g_body
         assign d_name   = cell_name[i-1];
         assign d_kind   = cell_kind[i-1];
         assign d_first  = cell_first[i-1];
         assign d_second = cell_second[i-1];
      end

      ssstk_cell #(
         .NAME_BITS (NAME_BITS)
      ) u_cell (
         .clock    (clock),
         .shift_en (scanning),
         .d_name   (d_name),
         .d_kind   (d_kind),
         .d_first  (d_first),
         .d_second (d_second),
         .q_name   (cell_name[i]),
         .q_kind   (cell_kind[i]),
         .q_first  (cell_first[i]),
         .q_second (cell_second[i])
      );
   end

   assign in_type   = req_tuser;
   assign in_name   = req_tdata[15:0];
   assign in_kind   = req_tdata[19:16];
   assign in_first  = req_tdata[51:20];
   assign in_second = req_tdata[83:52];
   assign in_slot   = req_tdata[93:84];

   assign in_name_w   = 32'(in_name);
   assign cnt_w       = 32'(count_ff);
   assign in_slot_w   = 32'(in_slot);
   assign idx_w       = 32'(rot_ff);
   assign hold_slot_w = 32'(slot_ff);
   assign cnt_next_w  = cnt_w + 32'd1;

   assign scanning  = (state_ff == ST_SCAN);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign req_fire  = req_tvalid && req_tready;
   assign last_step = (step_ff == LAST_IDX);

   always_comb begin
      case (op_ff)
         REQ_PUSH:   hit = (idx_w == cnt_w);
         REQ_LOOKUP: hit = (idx_w < cnt_w) && (cell_name[0] == name_ff)
                           && (!found_ff || (rot_ff > best_ff));
         REQ_READ:   hit = (idx_w == hold_slot_w);
         REQ_RENAME: hit = (idx_w == hold_slot_w);
         default:    hit = 1'b0;
      endcase
   end

   assign wr_all  = scanning && hit && (op_ff == REQ_PUSH);
   assign wr_name = scanning && hit && (op_ff == REQ_RENAME);

   // head entry as it leaves cell 0, with any write applied
   assign p_name   = (wr_all || wr_name) ? name_ff : cell_name[0];
   assign p_kind   = wr_all ? kind_ff   : cell_kind[0];
   assign p_first  = wr_all ? first_ff  : cell_first[0];
   assign p_second = wr_all ? second_ff : cell_second[0];
   assign pname_w  = 32'(p_name);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (in_type)
                  REQ_PUSH:   state_in = (cnt_w < STACK_DEPTH) ? ST_SCAN : ST_IDLE;
                  REQ_LOOKUP: state_in = ST_SCAN;
                  REQ_READ:   state_in = (in_slot_w < cnt_w) ? ST_SCAN : ST_IDLE;
                  REQ_RENAME: state_in = (in_slot_w < cnt_w) ? ST_SCAN : ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (last_step) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      case (state_ff)
         ST_IDLE: req_tready = rsp_free;
         ST_SCAN: req_tready = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      rot_in       = rot_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      name_in      = name_ff;
      kind_in      = kind_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      fslot_in     = fslot_ff;
      oname_in     = oname_ff;
      okind_in     = okind_ff;
      ofirst_in    = ofirst_ff;
      osecond_in   = osecond_ff;
      oconst_in    = oconst_ff;
      depth_in     = depth_ff;

      if (req_fire) begin
         op_in      = in_type;
         name_in    = in_name_w[NAME_BITS-1:0];
         kind_in    = in_kind;
         first_in   = in_first;
         second_in  = in_second;
         slot_in    = in_slot;
         found_in   = 1'b0;
         best_in    = '0;
         step_in    = '0;
         status_in  = STATUS_OK;
         fslot_in   = '0;
         oname_in   = '0;
         okind_in   = '0;
         ofirst_in  = '0;
         osecond_in = '0;
         oconst_in  = 1'b0;
         depth_in   = cnt_w[DEPTH_BITS-1:0];
         case (in_type)
            REQ_PUSH: begin
               if (cnt_w >= STACK_DEPTH) begin
                  status_in    = STATUS_FULL;
                  rsp_valid_in = 1'b1;
               end
            end
            REQ_LOOKUP: begin
            end
            REQ_READ, REQ_RENAME: begin
               if (in_slot_w >= cnt_w) begin
                  status_in    = STATUS_RANGE;
                  rsp_valid_in = 1'b1;
               end
            end
            REQ_TRUNCATE: begin
               rsp_valid_in = 1'b1;
               if (in_slot_w <= cnt_w) begin
                  count_in = CW'(in_slot);
                  depth_in = in_slot;
               end else begin
                  status_in = STATUS_RANGE;
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end

      if (scanning) begin
         rot_in  = (rot_ff == '0) ? LAST_IDX : rot_ff - 1'b1;
         step_in = last_step ? '0 : step_ff + 1'b1;
         if (hit) begin
            found_in   = 1'b1;
            best_in    = rot_ff;
            fslot_in   = idx_w[FOUND_BITS-1:0];
            oname_in   = pname_w[REQ_NAME_BITS-1:0];
            okind_in   = p_kind;
            ofirst_in  = p_first;
            osecond_in = p_second;
            oconst_in  = (p_kind == KIND_CONST);
         end
         if (last_step) begin
            rsp_valid_in = 1'b1;
            if (op_ff == REQ_PUSH) begin
               count_in = count_ff + 1'b1;
               depth_in = cnt_next_w[DEPTH_BITS-1:0];
            end
            status_in = ((op_ff == REQ_LOOKUP) && !found_in) ? STATUS_NOT_FOUND
                                                               : STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rot_ff       <= '0;
         step_ff      <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      name_ff    <= name_in;
      kind_ff    <= kind_in;
      first_ff   <= first_in;
      second_ff  <= second_in;
      slot_ff    <= slot_in;
      status_ff  <= status_in;
      fslot_ff   <= fslot_in;
      oname_ff   <= oname_in;
      okind_ff   <= okind_in;
      ofirst_ff  <= ofirst_in;
      osecond_ff <= osecond_in;
      oconst_ff  <= oconst_in;
      depth_ff   <= depth_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {depth_ff, oconst_ff, osecond_ff, ofirst_ff, okind_ff,
                        oname_ff, fslot_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= STACK_DEPTH)
      else $error("entry count past stack depth");

   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      scanning |-> !rsp_valid_ff && !req_tready)
      else $error("response or request open during scan");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire) || $past(scanning && last_step))
      else $error("response raised without a request or finished scan");

   a_ring_home: assert property (@(posedge clock) disable iff (reset)
      (scanning && last_step) |=> (rot_ff == $past(rot_in)) && (step_ff == '0))
      else $error("ring position lost at end of scan");

endmodule

### tb/sv/scoped_symbol_stack_tb.sv
`timescale 1ns / 1ps

module scoped_symbol_stack_tb;
   import ssstk_pkg::*;

   localparam int STACK_DEPTH = 512;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DIRECTED_ROWS = 25;

   localparam logic [REQ_TYPE_BITS-1:0] REQ_UNUSED_LO  = 3'd5;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_UNUSED_HI  = 3'd7;

   localparam logic [KIND_BITS-1:0] KIND_VAR    = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_LOCAL  = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_RETVAL = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_LIB    = 4'd8;

   typedef struct packed {
      logic [REQ_TYPE_BITS-1:0] op;
      logic [15:0]              name;
      logic [KIND_BITS-1:0]     kind;
      logic [31:0]              first;
      logic [31:0]              second;
      logic [SLOT_BITS-1:0]     slot;
   } request_type;

   typedef struct packed {
      status_type              status;
      logic [FOUND_BITS-1:0]   slot;
      logic [15:0]             name;
      logic [KIND_BITS-1:0]    kind;
      logic [31:0]             first;
      logic [31:0]             second;
      logic                    is_const;
      logic [DEPTH_BITS-1:0]   depth;
   } result_type;

   typedef struct packed {
      request_type           req;
      logic                  typed;
      status_type            exp_status;
      logic [DEPTH_BITS-1:0] exp_depth;
   } directed_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [REQ_TYPE_BITS-1:0] req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [1:0]               rsp_tuser;

   // predicted contents of the symbol stack
   logic [15:0]          sym_name [STACK_DEPTH];
   logic [KIND_BITS-1:0] sym_kind [STACK_DEPTH];
   logic [31:0]          sym_first [STACK_DEPTH];
   logic [31:0]          sym_second [STACK_DEPTH];
   int                   sym_count = 0;

   result_type  pending_results[$];
   logic [15:0] name_pool [16];
   int          mismatches = 0;
   int          cycles = 0;
   int          requests_sent = 0;

   scoped_symbol_stack dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycles >= 100000 && cycles < 250000) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 9);
      end
   end

   function automatic result_type predict_symbol_op(request_type rq);
      result_type r;
      int hit;
      int i;
      r = '0;
      r.status = STATUS_OK;
      hit = -1;
      case (rq.op)
         REQ_PUSH: begin
            if (sym_count >= STACK_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               sym_name[sym_count] = rq.name;
               sym_kind[sym_count] = rq.kind;
               sym_first[sym_count] = rq.first;
               sym_second[sym_count] = rq.second;
               hit = sym_count;
               sym_count++;
            end
         end
         REQ_LOOKUP: begin
            r.status = STATUS_NOT_FOUND;
            for (i = sym_count - 1; i >= 0 && hit < 0; i--) begin
               if (sym_name[i] == rq.name) hit = i;
            end
            if (hit >= 0) r.status = STATUS_OK;
         end
         REQ_READ, REQ_RENAME: begin
            if (int'(rq.slot) < sym_count) begin
               hit = rq.slot;
               if (rq.op == REQ_RENAME) sym_name[hit] = rq.name;
            end else begin
               r.status = STATUS_RANGE;
            end
         end
         REQ_TRUNCATE: begin
            if (int'(rq.slot) <= sym_count) sym_count = rq.slot;
            else r.status = STATUS_RANGE;
         end
         default: ;
      endcase
      if (hit >= 0) begin
         r.slot = FOUND_BITS'(hit);
         r.name = sym_name[hit];
         r.kind = sym_kind[hit];
         r.first = sym_first[hit];
         r.second = sym_second[hit];
         r.is_const = (sym_kind[hit] == KIND_CONST);
      end
      r.depth = DEPTH_BITS'(sym_count);
      return r;
   endfunction

   function automatic directed_row_type row(logic [REQ_TYPE_BITS-1:0] op, logic [15:0] name,
                                            logic [KIND_BITS-1:0] kind, logic [31:0] first,
                                            logic [31:0] second, logic [SLOT_BITS-1:0] slot,
                                            logic typed, status_type st,
                                            logic [DEPTH_BITS-1:0] depth);
      directed_row_type d;
      d.req = '{op, name, kind, first, second, slot};
      d.typed = typed;
      d.exp_status = st;
      d.exp_depth = depth;
      return d;
   endfunction

   // typed rows touch no entry, so all fields but status and depth are expected to be zero
   function automatic directed_row_type directed_row(int n);
      directed_row_type d;
      d = '0;
      case (n)
         0:  d = row(REQ_READ, 16'h0000, KIND_VAR, '0, '0, 10'd0, 1, STATUS_RANGE, 10'd0);
         1:  d = row(REQ_RENAME, 16'hffff, KIND_VAR, '0, '0, 10'd0, 1, STATUS_RANGE, 10'd0);
         2:  d = row(REQ_LOOKUP, 16'h0000, KIND_VAR, '0, '0, 10'd0, 1, STATUS_NOT_FOUND, 10'd0);
         3:  d = row(REQ_TRUNCATE, 16'h0000, KIND_VAR, '0, '0, 10'd0, 1, STATUS_OK, 10'd0);
         4:  d = row(REQ_TRUNCATE, 16'h0000, KIND_VAR, '0, '0, 10'd1, 1, STATUS_RANGE, 10'd0);
         5:  d = row(REQ_PUSH, 16'h0000, KIND_VAR, 32'h8000_0000, 32'h7fff_ffff, 10'd0,
                     0, STATUS_OK, '0);
         6:  d = row(REQ_PUSH, 16'hffff, KIND_LIB, 32'h7fff_ffff, 32'h8000_0000, 10'h3ff,
                     0, STATUS_OK, '0);
         7:  d = row(REQ_PUSH, 16'h1234, KIND_CONST, 32'hffff_ffff, 32'h0, 10'd0,
                     0, STATUS_OK, '0);
         8:  d = row(REQ_PUSH, 16'hffff, KIND_RETVAL, 32'h0, 32'hffff_ffff, 10'd0,
                     0, STATUS_OK, '0);
         9:  d = row(REQ_LOOKUP, 16'hffff, KIND_VAR, '0, '0, 10'd0, 0, STATUS_OK, '0);
         10: d = row(REQ_LOOKUP, 16'h0000, KIND_VAR, '0, '0, 10'd0, 0, STATUS_OK, '0);
         11: d = row(REQ_LOOKUP, 16'h5555, KIND_VAR, '0, '0, 10'd0, 1, STATUS_NOT_FOUND, 10'd4);
         12: d = row(REQ_READ, 16'h0000, KIND_VAR, '0, '0, 10'd2, 0, STATUS_OK, '0);
         13: d = row(REQ_READ, 16'h0000, KIND_VAR, '0, '0, 10'd4, 1, STATUS_RANGE, 10'd4);
         14: d = row(REQ_READ, 16'h0000, KIND_VAR, '0, '0, 10'h3ff, 1, STATUS_RANGE, 10'd4);
         15: d = row(REQ_RENAME, 16'h0000, KIND_VAR, '0, '0, 10'd3, 0, STATUS_OK, '0);
         16: d = row(REQ_LOOKUP, 16'hffff, KIND_VAR, '0, '0, 10'd0, 0, STATUS_OK, '0);
         17: d = row(REQ_LOOKUP, 16'h0000, KIND_VAR, '0, '0, 10'd0, 0, STATUS_OK, '0);
         18: d = row(REQ_RENAME, 16'hffff, KIND_VAR, '0, '0, 10'd512, 1, STATUS_RANGE, 10'd4);
         19: d = row(REQ_UNUSED_LO, 16'h0000, KIND_VAR, '0, '0, 10'd0, 1, STATUS_OK, 10'd4);
         20: d = row(REQ_UNUSED_HI, 16'hffff, KIND_LIB, 32'hffff_ffff, 32'hffff_ffff,
                     10'h3ff, 1, STATUS_OK, 10'd4);
         21: d = row(REQ_TRUNCATE, 16'h0000, KIND_VAR, '0, '0, 10'd512, 1, STATUS_RANGE, 10'd4);
         22: d = row(REQ_TRUNCATE, 16'h0000, KIND_VAR, '0, '0, 10'd2, 1, STATUS_OK, 10'd2);
         23: d = row(REQ_LOOKUP, 16'hffff, KIND_VAR, '0, '0, 10'd0, 0, STATUS_OK, '0);
         24: d = row(REQ_PUSH, 16'h1234, KIND_LOCAL, 32'h1, 32'hffff_fffe, 10'd0,
                     0, STATUS_OK, '0);
         default: ;
      endcase
      return d;
   endfunction

   function automatic request_type symbol_request(logic [REQ_TYPE_BITS-1:0] op,
                                                  logic [15:0] name,
                                                  logic [SLOT_BITS-1:0] slot);
      request_type rq;
      rq.op = op;
      rq.name = name;
      rq.kind = KIND_BITS'($urandom_range(KIND_LIB));
      rq.first = $urandom;
      rq.second = $urandom;
      rq.slot = slot;
      return rq;
   endfunction

   function automatic request_type random_request(bit filling);
      request_type rq;
      int pick;
      int live;
      live = sym_count;
      rq = symbol_request(REQ_PUSH, name_pool[$urandom_range(15)], '0);
      if ($urandom_range(3) == 0) rq.name = 16'($urandom);
      if (live > 0) rq.slot = SLOT_BITS'($urandom_range(live - 1));
      if (filling) pick = ($urandom_range(99) < 97) ? 0 : $urandom_range(99, 35);
      else pick = $urandom_range(99);
      if (pick < 35) begin
         rq.op = REQ_PUSH;
      end else if (pick < 60) begin
         rq.op = REQ_LOOKUP;
         if (live > 0 && $urandom_range(9) < 7) rq.name = sym_name[$urandom_range(live - 1)];
      end else if (pick < 75) begin
         rq.op = REQ_READ;
      end else if (pick < 85) begin
         rq.op = REQ_RENAME;
      end else if (pick < 95) begin
         rq.op = REQ_TRUNCATE;
         rq.slot = SLOT_BITS'(live - $urandom_range((live < 6) ? live : 6));
      end else begin
         // unused codes, or an index at or past the count
         if ($urandom_range(1) == 0) rq.op = REQ_TYPE_BITS'($urandom_range(REQ_UNUSED_HI,
                                                                           REQ_UNUSED_LO));
         else rq.op = REQ_TYPE_BITS'($urandom_range(REQ_TRUNCATE, REQ_READ));
         rq.slot = SLOT_BITS'($urandom_range((1 << SLOT_BITS) - 1, live));
      end
      return rq;
   endfunction

   task automatic issue(request_type rq, logic typed, result_type typed_result);
      result_type predicted;
      int gap;
      gap = 0;
      if (!(requests_sent >= 150 && requests_sent < 300) && $urandom_range(99) < 9) begin
         gap = $urandom_range(8, 1);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rq.op;
      req_tdata <= {2'b00, rq.slot, rq.second, rq.first, rq.kind, rq.name};
      do @(posedge clock); while (!req_tready);
      predicted = predict_symbol_op(rq);
      pending_results.push_back(typed ? typed_result : predicted);
      requests_sent++;
   endtask

   task automatic wait_for_results();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_tuser);
            check_field("found_slot", want.slot, rsp_tdata[8:0]);
            check_field("out_name", want.name, rsp_tdata[24:9]);
            check_field("out_kind", want.kind, rsp_tdata[28:25]);
            check_field("out_first", want.first, rsp_tdata[60:29]);
            check_field("out_second", want.second, rsp_tdata[92:61]);
            check_field("is_constant", want.is_const, rsp_tdata[93]);
            check_field("depth_now", want.depth, rsp_tdata[103:94]);
         end
      end
   end

   initial begin
      directed_row_type d;
      result_type typed_result;
      int n;
      name_pool[0] = 16'h0000;
      name_pool[1] = 16'hffff;
      for (n = 2; n < 16; n++) name_pool[n] = 16'($urandom);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         d = directed_row(n);
         typed_result = '0;
         typed_result.status = d.exp_status;
         typed_result.depth = d.exp_depth;
         issue(d.req, d.typed, typed_result);
      end

      repeat (20) issue(random_request(1'b0), 1'b0, '0);
      req_tvalid <= 1'b0;
      wait_for_results();

      // fill the stack, then work at the top of it
      while (sym_count < STACK_DEPTH) issue(random_request(1'b1), 1'b0, '0);
      issue(symbol_request(REQ_PUSH, name_pool[2], '0), 1'b0, '0);
      issue(symbol_request(REQ_PUSH, 16'hffff, '0), 1'b0, '0);
      issue(symbol_request(REQ_LOOKUP, sym_name[0], '0), 1'b0, '0);
      issue(symbol_request(REQ_LOOKUP, sym_name[STACK_DEPTH - 1], '0), 1'b0, '0);
      issue(symbol_request(REQ_READ, '0, 10'd511), 1'b0, '0);
      issue(symbol_request(REQ_READ, '0, 10'd512), 1'b0, '0);
      issue(symbol_request(REQ_RENAME, 16'hffff, 10'd511), 1'b0, '0);
      issue(symbol_request(REQ_LOOKUP, 16'hffff, '0), 1'b0, '0);
      issue(symbol_request(REQ_TRUNCATE, '0, 10'd513), 1'b0, '0);
      issue(symbol_request(REQ_TRUNCATE, '0, 10'd512), 1'b0, '0);
      issue(symbol_request(REQ_TRUNCATE, '0, 10'd0), 1'b0, '0);
      issue(symbol_request(REQ_LOOKUP, 16'hffff, '0), 1'b0, '0);
      issue(symbol_request(REQ_PUSH, name_pool[3], '0), 1'b0, '0);
      req_tvalid <= 1'b0;
      wait_for_results();

      repeat (15) issue(random_request(1'b0), 1'b0, '0);
      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (520) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### scoped_symbol_stack.f
design/ssstk_pkg.sv
design/ssstk_cell.sv
design/scoped_symbol_stack.sv
tb/sv/scoped_symbol_stack_tb.sv
